### rtl/swrs_pkg.sv
// Shared types and fixed widths for the sliding window rate statistics block.
// No dependencies; used by the divider and the top level.
`default_nettype none

package swrs_pkg;

	// sample and register field widths
	localparam int RATE_W = 40;
	localparam int LEN_W  = 9;

	// window length after reset
	localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage : swrs_pkg

`default_nettype wire

### rtl/swrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module swrs_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule : swrs_ram

`default_nettype wire

### rtl/swrs_div.sv
// Dual-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on swrs_pkg for the status struct.
`default_nettype none

module swrs_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 9
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [NUM_W-1:0]        num_a,
	input  wire  [NUM_W-1:0]        num_b,
	input  wire  [DEN_W-1:0]        den,
	output swrs_pkg::div_stat_t     stat,
	output logic [NUM_W-1:0]        quo_a,
	output logic [NUM_W-1:0]        quo_b
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_a_q;
	logic [DEN_W-1:0] rem_b_q;
	logic [NUM_W-1:0] quo_a_q;
	logic [NUM_W-1:0] quo_b_q;

	logic [DEN_W:0] sh_a;
	logic [DEN_W:0] sh_b;
	logic           ge_a;
	logic           ge_b;

	// shift next dividend bit into each partial remainder and trial-subtract
	always_comb begin
		sh_a = {rem_a_q, quo_a_q[NUM_W-1]};
		sh_b = {rem_b_q, quo_b_q[NUM_W-1]};
		ge_a = sh_a >= {1'b0, den_q};
		ge_b = sh_b >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= den;
			rem_a_q <= '0;
			rem_b_q <= '0;
			quo_a_q <= num_a;
			quo_b_q <= num_b;
		end else if (busy_q) begin
			rem_a_q <= ge_a ? DEN_W'(sh_a - {1'b0, den_q}) : sh_a[DEN_W-1:0];
			rem_b_q <= ge_b ? DEN_W'(sh_b - {1'b0, den_q}) : sh_b[DEN_W-1:0];
			quo_a_q <= {quo_a_q[NUM_W-2:0], ge_a};
			quo_b_q <= {quo_b_q[NUM_W-2:0], ge_b};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo_a     = quo_a_q;
	assign quo_b     = quo_b_q;

endmodule : swrs_div

`default_nettype wire

### rtl/sliding_window_rate_stats_core.sv
// Top level of the sliding window rate statistics block: sequencer, window RAM, divider.
// Depends on swrs_pkg, swrs_ram and swrs_div.
`default_nettype none

// Keeps a sliding window of read and write throughput samples (shared fill count and
// oldest position) in one RAM of WINDOW_DEPTH entries, and returns per input transaction
// the floor mean and the peak of each window. One transaction is handled at a time;
// a finished result waits in the output register while the next input is taken.
// Without a peak rescan an item passes through the append, divider start, divider wait
// and finish states, after the old-use state when the oldest sample is dropped; the
// divider yields one quotient bit per cycle. When a dropped sample was at least its peak,
// the samples left after the drop are walked through the single RAM read port before the
// append. A result still held in the output register stalls the sequencer before it
// returns to idle. No clearing pass: entries are read only after they are written.
// window_length above WINDOW_DEPTH acts as WINDOW_DEPTH; zero or one keeps a single
// sample. A lowered length shrinks the window by nothing: one sample is still dropped
// per item.
module sliding_window_rate_stats_core #(
	parameter int WINDOW_DEPTH = 256
) (
	input  wire          clk,
	input  wire          arst_n,
	// configuration write: window_length
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [8:0]   cfg_data,
	// input samples
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [79:0]  s_axis_tdata,   // [39:0] read_rate, [79:40] write_rate
	// results
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [159:0] m_axis_tdata    // [39:0] read_average, [79:40] read_peak,
	                                     // [119:80] write_average, [159:120] write_peak
);

	localparam int RATE_W = swrs_pkg::RATE_W;
	localparam int LEN_W  = swrs_pkg::LEN_W;
	localparam int AW     = $clog2(WINDOW_DEPTH);
	localparam int CW     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = RATE_W + CW;
	localparam int PW     = CW + 1;
	localparam int CMPW   = (CW > LEN_W) ? CW : LEN_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_OLD_USE   = 7'b0000010,
		ST_SCAN      = 7'b0000100,
		ST_APPEND    = 7'b0001000,
		ST_DIV_START = 7'b0010000,
		ST_DIV_WAIT  = 7'b0100000,
		ST_FINISH    = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    len_q;
	logic [AW-1:0]       oldest_q;
	logic [CW-1:0]       fill_q;
	logic [SUM_W-1:0]    rsum_q;
	logic [SUM_W-1:0]    wsum_q;
	logic [RATE_W-1:0]   rmax_q;
	logic [RATE_W-1:0]   wmax_q;
	logic                need_r_q;
	logic                need_w_q;
	logic [CW-1:0]       scan_cnt_q;
	logic [AW-1:0]       scan_ptr_q;
	logic                issue_s1;
	logic                m_valid_q;

	logic [RATE_W-1:0]   rd_q;
	logic [RATE_W-1:0]   wr_q;
	logic [RATE_W-1:0]   srmax_q;
	logic [RATE_W-1:0]   swmax_q;
	logic [159:0]        out_q;

	logic [2*RATE_W-1:0] ram_rdata;
	logic [AW-1:0]       ram_raddr;
	logic [AW-1:0]       ram_waddr;
	logic                ram_we;
	logic [RATE_W-1:0]   rgone;
	logic [RATE_W-1:0]   wgone;
	logic [CMPW-1:0]     eff_len;
	logic                drop;
	logic [PW-1:0]       pos_sum;
	logic                in_xact;
	logic                out_load;
	logic                div_start;
	swrs_pkg::div_stat_t div_stat;
	logic [SUM_W-1:0]    quo_r;
	logic [SUM_W-1:0]    quo_w;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
		idx_inc = (idx == LAST_IDX) ? '0 : AW'(idx + 1'b1);
	endfunction

	// effective length, drop decision, output register load
	always_comb begin
		eff_len  = (CMPW'(len_q) > CMPW'(WINDOW_DEPTH)) ? CMPW'(WINDOW_DEPTH) : CMPW'(len_q);
		drop     = (fill_q != '0) && (CMPW'(fill_q) >= eff_len);
		in_xact  = s_axis_tvalid && s_axis_tready;
		out_load = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);
	end

	// RAM access: oldest entry by default, walk pointer during rescan, append slot
	always_comb begin
		pos_sum   = PW'(oldest_q) + PW'(fill_q);
		ram_waddr = (pos_sum >= PW'(WINDOW_DEPTH)) ? AW'(pos_sum - PW'(WINDOW_DEPTH))
		                                           : AW'(pos_sum);
		ram_we    = state_q == ST_APPEND;
		ram_raddr = (state_q == ST_SCAN) ? scan_ptr_q : oldest_q;
		rgone     = ram_rdata[RATE_W-1:0];
		wgone     = ram_rdata[2*RATE_W-1:RATE_W];
		div_start = state_q == ST_DIV_START;
	end

	swrs_ram #(
		.WIDTH (2 * RATE_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({wr_q, rd_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	swrs_div #(
		.NUM_W (SUM_W),
		.DEN_W (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_a  (rsum_q),
		.num_b  (wsum_q),
		.den    (fill_q),
		.stat   (div_stat),
		.quo_a  (quo_r),
		.quo_b  (quo_w)
	);

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= swrs_pkg::LEN_RESET;
			oldest_q   <= '0;
			fill_q     <= '0;
			rsum_q     <= '0;
			wsum_q     <= '0;
			rmax_q     <= '0;
			wmax_q     <= '0;
			need_r_q   <= 1'b0;
			need_w_q   <= 1'b0;
			scan_cnt_q <= '0;
			scan_ptr_q <= '0;
			issue_s1   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_q <= cfg_data;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						state_q <= drop ? ST_OLD_USE : ST_APPEND;
					end
				end
				ST_OLD_USE: begin
					rsum_q     <= rsum_q - SUM_W'(rgone);
					wsum_q     <= wsum_q - SUM_W'(wgone);
					oldest_q   <= idx_inc(oldest_q);
					fill_q     <= fill_q - 1'b1;
					need_r_q   <= rgone >= rmax_q;
					need_w_q   <= wgone >= wmax_q;
					scan_ptr_q <= idx_inc(oldest_q);
					scan_cnt_q <= '0;
					state_q    <= (rgone >= rmax_q || wgone >= wmax_q) ? ST_SCAN : ST_APPEND;
				end
				ST_SCAN: begin
					if (scan_cnt_q != fill_q) begin
						issue_s1   <= 1'b1;
						scan_cnt_q <= scan_cnt_q + 1'b1;
						scan_ptr_q <= idx_inc(scan_ptr_q);
					end else begin
						issue_s1 <= 1'b0;
						if (!issue_s1) begin
							if (need_r_q) begin
								rmax_q <= srmax_q;
							end
							if (need_w_q) begin
								wmax_q <= swmax_q;
							end
							state_q <= ST_APPEND;
						end
					end
				end
				ST_APPEND: begin
					fill_q  <= fill_q + 1'b1;
					rsum_q  <= rsum_q + SUM_W'(rd_q);
					wsum_q  <= wsum_q + SUM_W'(wr_q);
					if (rd_q > rmax_q) begin
						rmax_q <= rd_q;
					end
					if (wr_q > wmax_q) begin
						wmax_q <= wr_q;
					end
					state_q <= ST_DIV_START;
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: input samples, rescan maxima, output register
	always_ff @(posedge clk) begin
		if (in_xact) begin
			rd_q <= s_axis_tdata[RATE_W-1:0];
			wr_q <= s_axis_tdata[2*RATE_W-1:RATE_W];
		end
		if (state_q == ST_OLD_USE) begin
			srmax_q <= '0;
			swmax_q <= '0;
		end else if (state_q == ST_SCAN && issue_s1) begin
			if (rgone > srmax_q) begin
				srmax_q <= rgone;
			end
			if (wgone > swmax_q) begin
				swmax_q <= wgone;
			end
		end
		if (out_load) begin
			out_q <= {wmax_q, quo_w[RATE_W-1:0], rmax_q, quo_r[RATE_W-1:0]};
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	// fill count never exceeds the RAM depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_DEPTH))
		else $error("fill count above window depth");

	// one item in flight: no input taken in the cycle after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// rescan walk never runs past the live samples
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_cnt_q <= fill_q))
		else $error("rescan walked past the window");

	// divider is only started when idle
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

endmodule : sliding_window_rate_stats_core

`default_nettype wire
